// File: rtl/core/lzd_pkg.sv
// lzd_pkg: shared types, codes and helpers for the LZ4 block decoder.
// No dependencies; imported by the channel interfaces and the top level.
package lzd_pkg;

  localparam int unsigned WINDOW_BYTES_DEF = 65536;

  localparam logic [3:0] NIB_EXT    = 4'hf;
  localparam logic [4:0] MATCH_BIAS = 5'd4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OFFSET = 2'd1,
    ST_WRONG_KIND = 2'd2,
    ST_AFTER_DONE = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [7:0] {
    PH_TOKEN  = 8'b0000_0001,
    PH_LITEXT = 8'b0000_0010,
    PH_LIT    = 8'b0000_0100,
    PH_OFFLO  = 8'b0000_1000,
    PH_OFFHI  = 8'b0001_0000,
    PH_MATEXT = 8'b0010_0000,
    PH_MATCH  = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       need_tick;
    logic       done_res;
    logic [1:0] status;
  } res_t;

  // saturating 16-bit add
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

endpackage

// File: rtl/core/lzd_if.sv
// lzd_if: valid/ready channel interfaces for compressed input and decoded results.
// Depends on lzd_pkg for the payload types.
interface lzd_in_if import lzd_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lzd_out_if import lzd_pkg::*;;
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/lz4_block_decoder_unit.sv
// LZ4 block decoder. A beat's result passes through the history read stage, then the output
// register. Throughput: one beat per cycle, ticks included, while out_res.ready does not stall
// the output; a match with offset 1 is served by forwarding from the output register.
// Reset (rst_n, synchronous): control state and packed_length cleared; the history
// memory is not cleared and needs no clearing pass.
// Depends on lzd_pkg and lzd_if.
module lz4_block_decoder_unit import lzd_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  lzd_in_if.sink      in_item,
  lzd_out_if.source   out_res
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  // control state
  phase_t        phase_r, phase_nxt;
  logic [3:0]    match_nibble_r, match_nibble_nxt;
  logic [15:0]   run_count_r, run_count_nxt;
  logic [15:0]   bytes_consumed_r, bytes_consumed_nxt;
  logic [15:0]   match_offset_r, match_offset_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [16:0]   bytes_written_r, bytes_written_nxt;
  logic [15:0]   packed_length_r;

  // read stage
  logic          s1_v_r;
  res_t          s1_res_r;
  logic          s1_match_r;
  logic          s1_wr_r;
  logic          s1_fwd_r;
  logic [AW-1:0] s1_waddr_r;
  logic [7:0]    rd_q_r;

  // output register
  logic          out_v_r;
  res_t          out_res_r;

  logic [7:0]    hist_mem [WINDOW_BYTES];

  logic          out_free, s1_move, accept;
  res_t          res_nxt;
  logic          wr_nxt, match_nxt;
  logic [16:0]   rd17;
  logic [AW-1:0] rd_addr;
  logic          fwd_nxt;
  logic [7:0]    s1_byte;
  res_t          s1_out;
  logic [15:0]   run_dec;
  logic [15:0]   off_cand;
  logic [16:0]   off_full;
  logic          bad_off;
  logic [7:0]    b;

  assign out_free = !out_v_r || out_res.ready;
  assign s1_move  = s1_v_r && out_free;
  assign in_item.ready = !s1_v_r || out_free;
  assign accept   = in_item.valid && in_item.ready;

  assign b        = in_item.data.in_byte;
  assign run_dec  = (run_count_r != 16'd0) ? run_count_r - 16'd1 : 16'd0;
  // offset as it stands once the match length is complete
  assign off_cand = (phase_r == PH_OFFHI) ? {b, match_offset_r[7:0]} : match_offset_r;
  assign off_full = {1'b0, off_cand};
  assign bad_off  = (off_cand == 16'd0) || (off_full > bytes_written_r) ||
                    (off_full > 17'(WINDOW_BYTES));

  // ring read address for a tick: wp - offset modulo the window
  always_comb begin
    if ({1'b0, 16'(wp_r)} >= {1'b0, match_offset_r}) begin
      rd17 = {1'b0, 16'(wp_r)} - {1'b0, match_offset_r};
    end else begin
      rd17 = {1'b0, 16'(wp_r)} + 17'(WINDOW_BYTES) - {1'b0, match_offset_r};
    end
  end
  assign rd_addr = rd17[AW-1:0];
  // previous beat's write lands on the same edge as this read
  assign fwd_nxt = match_nxt && s1_v_r && s1_wr_r && (s1_waddr_r == rd_addr);

  always_comb begin
    phase_nxt          = phase_r;
    match_nibble_nxt   = match_nibble_r;
    run_count_nxt      = run_count_r;
    bytes_consumed_nxt = bytes_consumed_r;
    match_offset_nxt   = match_offset_r;
    wp_nxt             = wp_r;
    bytes_written_nxt  = bytes_written_r;
    res_nxt            = '0;
    res_nxt.status     = ST_OK;
    wr_nxt             = 1'b0;
    match_nxt          = 1'b0;

    if (phase_r == PH_DONE) begin
      res_nxt.status = ST_AFTER_DONE;
    end else if (in_item.data.cmd == CMD_TICK) begin
      if (phase_r != PH_MATCH) begin
        res_nxt.status = ST_WRONG_KIND;
      end else begin
        res_nxt.out_valid = 1'b1;
        match_nxt         = 1'b1;
        wr_nxt            = 1'b1;
        run_count_nxt     = run_dec;
        if (run_dec == 16'd0) phase_nxt = PH_TOKEN;
      end
    end else if (phase_r == PH_MATCH) begin
      res_nxt.status = ST_WRONG_KIND;
    end else begin
      bytes_consumed_nxt = sat_add16(bytes_consumed_r, 16'd1);
      unique case (phase_r)
        PH_TOKEN: begin
          match_nibble_nxt = b[3:0];
          run_count_nxt    = {12'd0, b[7:4]};
          if (b[7:4] == 4'd0)         phase_nxt = PH_OFFLO;
          else if (b[7:4] == NIB_EXT) phase_nxt = PH_LITEXT;
          else                        phase_nxt = PH_LIT;
        end
        PH_LITEXT: begin
          run_count_nxt = sat_add16(run_count_r, {8'd0, b});
          if (b != 8'hff) phase_nxt = PH_LIT;
        end
        PH_LIT: begin
          res_nxt.out_valid = 1'b1;
          res_nxt.out_byte  = b;
          wr_nxt            = 1'b1;
          run_count_nxt     = run_dec;
          if (run_dec == 16'd0) begin
            phase_nxt = (bytes_consumed_nxt >= packed_length_r) ? PH_DONE : PH_OFFLO;
          end
        end
        PH_OFFLO: begin
          match_offset_nxt = {8'd0, b};
          phase_nxt        = PH_OFFHI;
        end
        PH_OFFHI: begin
          match_offset_nxt = {b, match_offset_r[7:0]};
          run_count_nxt    = {11'd0, {1'b0, match_nibble_r} + MATCH_BIAS};
          if (match_nibble_r == NIB_EXT) begin
            phase_nxt = PH_MATEXT;
          end else if (bad_off) begin
            phase_nxt      = PH_TOKEN;
            res_nxt.status = ST_BAD_OFFSET;
          end else begin
            phase_nxt = PH_MATCH;
          end
        end
        PH_MATEXT: begin
          run_count_nxt = sat_add16(run_count_r, {8'd0, b});
          if (b != 8'hff) begin
            if (bad_off) begin
              phase_nxt      = PH_TOKEN;
              res_nxt.status = ST_BAD_OFFSET;
            end else begin
              phase_nxt = PH_MATCH;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    if (wr_nxt) begin
      wp_nxt = (wp_r == AW'(WINDOW_BYTES - 1)) ? '0 : wp_r + AW'(1);
      if (!bytes_written_r[16]) bytes_written_nxt = bytes_written_r + 17'd1;
    end

    res_nxt.need_tick = (phase_nxt == PH_MATCH);
    res_nxt.done_res  = (phase_nxt == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_TOKEN;
      match_nibble_r   <= '0;
      run_count_r      <= '0;
      bytes_consumed_r <= '0;
      match_offset_r   <= '0;
      wp_r             <= '0;
      bytes_written_r  <= '0;
      packed_length_r  <= '0;
    end else begin
      if (cfg_we) packed_length_r <= cfg_wdata;
      if (accept) begin
        phase_r          <= phase_nxt;
        match_nibble_r   <= match_nibble_nxt;
        run_count_r      <= run_count_nxt;
        bytes_consumed_r <= bytes_consumed_nxt;
        match_offset_r   <= match_offset_nxt;
        wp_r             <= wp_nxt;
        bytes_written_r  <= bytes_written_nxt;
      end
    end
  end

  // read stage and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept)       s1_v_r <= 1'b1;
      else if (s1_move) s1_v_r <= 1'b0;
      if (s1_move)       out_v_r <= 1'b1;
      else if (out_free) out_v_r <= 1'b0;
    end
  end

  assign s1_byte = !s1_match_r ? s1_res_r.out_byte :
                   (s1_fwd_r ? out_res_r.out_byte : rd_q_r);

  always_comb begin
    s1_out          = s1_res_r;
    s1_out.out_byte = s1_byte;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r   <= res_nxt;
      s1_match_r <= match_nxt;
      s1_wr_r    <= wr_nxt;
      s1_fwd_r   <= fwd_nxt;
      s1_waddr_r <= wp_r;
    end
    if (s1_move) out_res_r <= s1_out;
  end

  // history memory: one read on tick accept, one write as a literal or match byte leaves the read stage
  always_ff @(posedge clk) begin
    if (accept && match_nxt) rd_q_r <= hist_mem[rd_addr];
    if (s1_move && s1_wr_r)  hist_mem[s1_waddr_r] <= s1_byte;
  end

  assign out_res.valid = out_v_r;
  assign out_res.data  = out_res_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |=> s1_v_r && $stable(s1_waddr_r) && $stable(s1_res_r))
    else $error("read stage lost or changed a stalled beat");

  a_fwd_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_fwd_r |-> s1_match_r)
    else $error("forwarding flagged on a non-match beat");

  a_match_offset: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MATCH |-> match_offset_r != 16'd0 && {1'b0, match_offset_r} <= bytes_written_r)
    else $error("match copy running with an invalid offset");

  a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.status == ST_AFTER_DONE |-> out_res_r.done_res)
    else $error("input-after-done result without done flag");

endmodule
